// ----- sv/cakb_pkg.sv -----
// Shared widths, register map and reset values for the clipped alpha-key blitter.
package cakb_pkg;

    localparam int POS_W   = 14;
    localparam int DIM_W   = 13;
    localparam int ALPHA_W = 8;
    localparam int PIX_W   = 32;
    localparam int WADDR_W = 24;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_POS_X           = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_Y           = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_HEIGHT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 3'd6;

    localparam logic [POS_W-1:0]   POS_RESET   = '0;
    localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd100;

endpackage

// ----- sv/clipped_alpha_key_blit.sv -----
// Clipped sprite blitter: alpha-keyed, window-clipped pixel writes with linear address.
// A request passes the input register, then the result register, onto the m_ channel.
// Throughput: one pixel per clock unless m_ready stalls; the input and result registers
// form a two-stage pipeline; an empty input register takes a pixel while m_ready is low.
// Reset (aresetn low, synchronous): pipeline emptied, column and row counters cleared,
// registers return to pos 0, all sizes 1 and alpha threshold 100.
module clipped_alpha_key_blit
    import cakb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    // APB-style configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // source pixel stream
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_W-1:0]    s_source_pixel,
    // window write stream
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_write_enable,
    output logic [WADDR_W-1:0]  m_window_address,
    output logic [PIX_W-1:0]    m_pixel_value,
    output logic                m_sprite_end
);

    // Counter width covers positions 0 .. MAX_DIM-1; effective sizes reach MAX_DIM.
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int EFF_W = CNT_W + 1;
    // Common width for comparing register values against clamped sizes.
    localparam int CMP_W = (EFF_W > DIM_W) ? EFF_W : DIM_W;
    // Signed width for window coordinates (placement plus counter).
    localparam int SGN_W = ((POS_W > CMP_W + 1) ? POS_W : CMP_W + 1) + 1;
    localparam int PRD_W = CNT_W + EFF_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   pos_x_reg;
    logic [POS_W-1:0]   pos_y_reg;
    logic [DIM_W-1:0]   sprite_width_reg;
    logic [DIM_W-1:0]   sprite_height_reg;
    logic [DIM_W-1:0]   window_width_reg;
    logic [DIM_W-1:0]   window_height_reg;
    logic [ALPHA_W-1:0] alpha_threshold_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg           <= POS_RESET;
            pos_y_reg           <= POS_RESET;
            sprite_width_reg    <= DIM_RESET;
            sprite_height_reg   <= DIM_RESET;
            window_width_reg    <= DIM_RESET;
            window_height_reg   <= DIM_RESET;
            alpha_threshold_reg <= ALPHA_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_POS_X:           pos_x_reg           <= pwdata[POS_W-1:0];
                REG_POS_Y:           pos_y_reg           <= pwdata[POS_W-1:0];
                REG_SPRITE_WIDTH:    sprite_width_reg    <= pwdata[DIM_W-1:0];
                REG_SPRITE_HEIGHT:   sprite_height_reg   <= pwdata[DIM_W-1:0];
                REG_WINDOW_WIDTH:    window_width_reg    <= pwdata[DIM_W-1:0];
                REG_WINDOW_HEIGHT:   window_height_reg   <= pwdata[DIM_W-1:0];
                REG_ALPHA_THRESHOLD: alpha_threshold_reg <= pwdata[ALPHA_W-1:0];
                default: ; // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_POS_X:           prdata = APB_DW'(pos_x_reg);
            REG_POS_Y:           prdata = APB_DW'(pos_y_reg);
            REG_SPRITE_WIDTH:    prdata = APB_DW'(sprite_width_reg);
            REG_SPRITE_HEIGHT:   prdata = APB_DW'(sprite_height_reg);
            REG_WINDOW_WIDTH:    prdata = APB_DW'(window_width_reg);
            REG_WINDOW_HEIGHT:   prdata = APB_DW'(window_height_reg);
            REG_ALPHA_THRESHOLD: prdata = APB_DW'(alpha_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes: zero acts as one, anything above MAX_DIM is clamped
    // ------------------------------------------------------------------
    function automatic logic [CMP_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [CMP_W-1:0] r;
        if (v == '0) begin
            r = CMP_W'(1);
        end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
            r = CMP_W'(MAX_DIM);
        end else begin
            r = CMP_W'(v);
        end
        return r;
    endfunction

    logic [CMP_W-1:0] sw_eff;
    logic [CMP_W-1:0] sh_eff;
    logic [CMP_W-1:0] ww_eff;
    logic [CMP_W-1:0] wh_eff;

    assign sw_eff = eff_dim(sprite_width_reg);
    assign sh_eff = eff_dim(sprite_height_reg);
    assign ww_eff = eff_dim(window_width_reg);
    assign wh_eff = eff_dim(window_height_reg);

    // ------------------------------------------------------------------
    // Handshake: the result register advances when empty or taken; the
    // input register refills whenever its content moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_advance;
    logic in_accept;

    assign out_advance = !m_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || out_advance;
    assign in_accept   = s_valid && s_ready;
    assign m_valid     = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Raster counters: advance on each accepted request, wrap at sprite size
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] column_count_reg;
    logic [CNT_W-1:0] column_count_next;
    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] row_count_next;

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (CMP_W'(column_count_reg) + CMP_W'(1) >= sw_eff) begin
            column_count_next = '0;
            if (CMP_W'(row_count_reg) + CMP_W'(1) >= sh_eff) begin
                row_count_next = '0;
            end else begin
                row_count_next = row_count_reg + CNT_W'(1);
            end
        end else begin
            column_count_next = column_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (in_accept) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register: pixel plus the sprite position it belongs to
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CNT_W-1:0] s1_column_reg;
    logic [CNT_W-1:0] s1_row_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pixel_reg  <= s_source_pixel;
            s1_column_reg <= column_count_reg;
            s1_row_reg    <= row_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Per-pixel work: clip, alpha key, multiply-add for the linear address
    // ------------------------------------------------------------------
    logic signed [SGN_W-1:0] win_x;
    logic signed [SGN_W-1:0] win_y;
    logic                    in_window;
    logic                    alpha_pass;
    logic                    wr_en;
    logic                    last_pixel;
    logic [PRD_W-1:0]        row_base;
    logic [PRD_W:0]          lin_addr;

    assign win_x = SGN_W'(signed'(pos_x_reg)) + signed'(SGN_W'(s1_column_reg));
    assign win_y = SGN_W'(signed'(pos_y_reg)) + signed'(SGN_W'(s1_row_reg));

    assign in_window = (win_x >= 0) && (win_x < signed'(SGN_W'(ww_eff)))
                    && (win_y >= 0) && (win_y < signed'(SGN_W'(wh_eff)));
    assign alpha_pass = s1_pixel_reg[PIX_W-1 -: ALPHA_W] > alpha_threshold_reg;
    assign wr_en      = in_window && alpha_pass;

    // Inside the window both coordinates are below MAX_DIM, so the low bits suffice.
    assign row_base = PRD_W'(win_y[CNT_W-1:0]) * PRD_W'(ww_eff[EFF_W-1:0]);
    assign lin_addr = (PRD_W + 1)'(row_base) + (PRD_W + 1)'(win_x[CNT_W-1:0]);

    assign last_pixel = (CMP_W'(s1_column_reg) == sw_eff - CMP_W'(1))
                     && (CMP_W'(s1_row_reg) == sh_eff - CMP_W'(1));

    // ------------------------------------------------------------------
    // Result register: hold while the consumer stalls
    // ------------------------------------------------------------------
    logic                 m_write_enable_reg;
    logic [WADDR_W-1:0]   m_window_address_reg;
    logic [PIX_W-1:0]     m_pixel_value_reg;
    logic                 m_sprite_end_reg;

    always_ff @(posedge aclk) begin
        if (out_advance && s1_valid_reg) begin
            m_write_enable_reg   <= wr_en;
            m_window_address_reg <= wr_en ? WADDR_W'(lin_addr) : '0;
            m_pixel_value_reg    <= s1_pixel_reg;
            m_sprite_end_reg     <= last_pixel;
        end
    end

    assign m_write_enable   = m_write_enable_reg;
    assign m_window_address = m_window_address_reg;
    assign m_pixel_value    = m_pixel_value_reg;
    assign m_sprite_end     = m_sprite_end_reg;

endmodule

// ----- sv/cakb_checker.sv -----
// Port-level checker for the clipped alpha-key blitter, bound to the top level.
module cakb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_write_enable,
    input logic [23:0] m_window_address,
    input logic [31:0] m_pixel_value
);

    // a stalled result request must hold its value
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_value)
            && $stable(m_window_address) && $stable(m_write_enable))
        else $error("result request changed while stalled");

    // suppressed writes carry a zero address
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_window_address == '0)
        else $error("address not zero on a suppressed write");

    // a taken result always frees room for a new pixel
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although output is draining");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind clipped_alpha_key_blit cakb_checker u_cakb_checker (.*);
